>>> hdl/phgm_pkg.sv
package phgm_pkg;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int REG_COUNT = 8;
    localparam int CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIN_X_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_X_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_Y_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLIND_X_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLIND_X_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLIND_Y_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLIND_Y_MAX = 3'd7;

    // register reset values, in index order
    localparam logic signed [CFG_W-1:0] CFG_RESET [REG_COUNT] = '{
        -16'sd5000, 16'sd5000, -16'sd5000, 16'sd5000,
        -16'sd300, 16'sd300, -16'sd300, 16'sd300
    };

    // shift of the fixed-point reciprocal used for the cell division
    localparam int DIV_SHIFT = 24;

    // operation codes
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // result status codes
    localparam logic [2:0] ST_STORED  = 3'd0;
    localparam logic [2:0] ST_OUTSIDE = 3'd1;
    localparam logic [2:0] ST_BLIND   = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_CLEARED = 3'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [15:0] x_mm;
        logic signed [15:0] y_mm;
        logic signed [15:0] z_mm;
        logic [6:0]         read_row;
        logic [6:0]         read_col;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] height_mm;
        logic               filled;
        logic [2:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_REM,
        S_IDX,
        S_ADR,
        S_LAT,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

>>> hdl/point_height_grid_max.sv
// Maximum-height elevation grid built from a stream of 3-D points.
// Input channel (valid/ready) carries one item: clear grid, add point or read cell.
// Output channel (valid/ready) returns one result item for every input item.
// Configuration is a plain write port (enable, index, data) for the window and
// blind-zone bounds; write it only while the block is idle.
// The grid lives in one memory of GRID_DIM*GRID_DIM words (filled mark and height)
// with a registered read; the block handles one item at a time.
// Steps from acceptance to o_out_valid; the next item can be taken once the result is loaded:
//   add point stored: reciprocal multiply, remainder multiply, index check,
//     address, memory read, read-modify-write
//   add point past the window's cell count or the grid: multiplies, index check
//   add point dropped by the window or blind zone: result only
//   read cell: address, memory read, result; a cell outside the grid: result only
//   clear: all GRID_DIM*GRID_DIM words, one memory word cleared per cycle, then result
// After reset the same clearing pass runs over all GRID_DIM*GRID_DIM words with
// o_in_ready low; configuration writes are taken during it.
// A stalled receiver holds the result in the output register; the next item
// is still accepted and runs until its own result is ready to be loaded.
module point_height_grid_max
    import phgm_pkg::*;
#(
    parameter int GRID_DIM = 128,
    parameter int CELL_MM  = 100
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int CELLS   = GRID_DIM * GRID_DIM;
    localparam int AW      = $clog2(CELLS);
    localparam int IW      = $clog2(GRID_DIM);
    localparam int CW      = $clog2(CELL_MM + 1);
    localparam int RECIP_W = DIV_SHIFT + 1;
    localparam int MUL_W   = 16 + RECIP_W;
    localparam int QC_W    = 16 + CW;

    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'((64'd1 << DIV_SHIFT) / CELL_MM);
    localparam logic [CW-1:0]      CELL_C    = CW'(CELL_MM);
    localparam logic [CW:0]        CELL_R    = (CW+1)'(CELL_MM);
    localparam logic [17:0]        CELL_G    = 18'(CELL_MM);
    localparam logic [16:0]        GRID_Q    = 17'(GRID_DIM);
    localparam logic [15:0]        GRID_16   = 16'(GRID_DIM);
    localparam logic [AW-1:0]      GRID_A    = AW'(GRID_DIM);
    localparam logic [AW-1:0]      LAST_ADDR = AW'(CELLS - 1);

    t_state r_state, n_state;

    logic signed [CFG_W-1:0] r_cfg [REG_COUNT];
    logic [AW-1:0]           r_sweep;

    logic [15:0]        r_off_x, r_off_y, r_gap_x, r_gap_y;
    logic signed [15:0] r_z;
    logic [15:0]        r_q_x, r_q_y;
    logic [QC_W-1:0]    r_qc_x, r_qc_y;
    logic [IW-1:0]      r_row, r_col;
    logic [AW-1:0]      r_addr;
    logic [2:0]         r_status;
    logic               r_rd_mem, r_wr_mem;

    logic [16:0]        mem [CELLS];
    logic [16:0]        r_mem_q;

    logic               r_out_valid;
    t_out_item          r_out_item;

    // combinational signals
    logic signed [15:0] win_x_min, win_x_max, win_y_min, win_y_max;
    logic signed [15:0] bl_x_min, bl_x_max, bl_y_min, bl_y_max;
    logic               in_win, in_blind, rd_ok;
    logic signed [16:0] dx, dy, gx, gy;
    logic [MUL_W-1:0]   mul_x, mul_y;
    logic [QC_W-1:0]    qc_x, qc_y;
    logic [CW:0]        rem_raw_x, rem_raw_y, rem_x, rem_y;
    logic               ge_x, ge_y;
    logic [16:0]        q_x, q_y;
    logic               drop;
    logic [AW-1:0]      addr;
    logic               mem_f;
    logic signed [15:0] mem_h, new_h;
    logic               accept, sweeping, sweep_last, out_load;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [16:0]        mem_wd;

    // configuration fields
    assign win_x_min = r_cfg[REG_WIN_X_MIN];
    assign win_x_max = r_cfg[REG_WIN_X_MAX];
    assign win_y_min = r_cfg[REG_WIN_Y_MIN];
    assign win_y_max = r_cfg[REG_WIN_Y_MAX];
    assign bl_x_min  = r_cfg[REG_BLIND_X_MIN];
    assign bl_x_max  = r_cfg[REG_BLIND_X_MAX];
    assign bl_y_min  = r_cfg[REG_BLIND_Y_MIN];
    assign bl_y_max  = r_cfg[REG_BLIND_Y_MAX];

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_cfg[i] <= CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_index] <= $signed(i_cfg_data);
        end
    end

    // window and blind-zone checks on the incoming point
    assign in_win = (i_in_item.x_mm >= win_x_min) && (i_in_item.x_mm <= win_x_max) &&
                    (i_in_item.y_mm >= win_y_min) && (i_in_item.y_mm <= win_y_max);
    assign in_blind = (i_in_item.x_mm >= bl_x_min) && (i_in_item.x_mm <= bl_x_max) &&
                      (i_in_item.y_mm >= bl_y_min) && (i_in_item.y_mm <= bl_y_max);
    assign rd_ok = (16'(i_in_item.read_row) < GRID_16) && (16'(i_in_item.read_col) < GRID_16);

    // offsets from the window minimum and gaps to the window maximum
    assign dx = {i_in_item.x_mm[15], i_in_item.x_mm} - {win_x_min[15], win_x_min};
    assign dy = {i_in_item.y_mm[15], i_in_item.y_mm} - {win_y_min[15], win_y_min};
    assign gx = {win_x_max[15], win_x_max} - {i_in_item.x_mm[15], i_in_item.x_mm};
    assign gy = {win_y_max[15], win_y_max} - {i_in_item.y_mm[15], i_in_item.y_mm};

    // quotient estimate by reciprocal, low by at most one
    assign mul_x = MUL_W'(r_off_x) * MUL_W'(RECIP);
    assign mul_y = MUL_W'(r_off_y) * MUL_W'(RECIP);

    // estimate times the cell size
    assign qc_x = QC_W'(r_q_x) * QC_W'(CELL_C);
    assign qc_y = QC_W'(r_q_y) * QC_W'(CELL_C);

    // remainder correction and grid range check
    assign rem_raw_x = (CW+1)'(r_off_x - r_qc_x[15:0]);
    assign rem_raw_y = (CW+1)'(r_off_y - r_qc_y[15:0]);
    assign ge_x      = rem_raw_x >= CELL_R;
    assign ge_y      = rem_raw_y >= CELL_R;
    assign rem_x     = ge_x ? rem_raw_x - CELL_R : rem_raw_x;
    assign rem_y     = ge_y ? rem_raw_y - CELL_R : rem_raw_y;
    assign q_x       = 17'(r_q_x) + 17'(ge_x);
    assign q_y       = 17'(r_q_y) + 17'(ge_y);
    // the index reaches the window's cell count when gap plus remainder < cell size
    assign drop = (18'(r_gap_x) + 18'(rem_x) < CELL_G) || (q_x >= GRID_Q) ||
                  (18'(r_gap_y) + 18'(rem_y) < CELL_G) || (q_y >= GRID_Q);

    // cell address
    assign addr = AW'(AW'(r_row) * GRID_A) + AW'(r_col);

    // read-modify-write of the cell word
    assign mem_f = r_mem_q[16];
    assign mem_h = $signed(r_mem_q[15:0]);
    assign new_h = (mem_f && (r_z <= mem_h)) ? mem_h : r_z;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_item.op)
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_ADD:   n_state = (in_win && !in_blind) ? S_DIV : S_DONE;
                        default:  n_state = rd_ok ? S_ADR : S_DONE;
                    endcase
                end
            end
            S_DIV:   n_state = S_REM;
            S_REM:   n_state = S_IDX;
            S_IDX:   n_state = drop ? S_DONE : S_ADR;
            S_ADR:   n_state = S_LAT;
            S_LAT:   n_state = S_DONE;
            S_CLEAR: begin
                if (sweep_last) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        accept     = o_in_ready && i_in_valid;
        sweeping   = (r_state == S_INIT) || (r_state == S_CLEAR);
        sweep_last = sweeping && (r_sweep == LAST_ADDR);
        out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        mem_we     = sweeping || (out_load && r_wr_mem);
        mem_wa     = sweeping ? r_sweep : r_addr;
        mem_wd     = sweeping ? 17'd0 : {1'b1, new_h};
    end

    // state register and clearing counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sweep <= '0;
        end else begin
            r_state <= n_state;
            if (sweeping) begin
                r_sweep <= sweep_last ? '0 : r_sweep + AW'(1);
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_off_x <= dx[15:0];
            r_off_y <= dy[15:0];
            r_gap_x <= gx[15:0];
            r_gap_y <= gy[15:0];
            r_z     <= i_in_item.z_mm;
            r_row   <= IW'(16'(i_in_item.read_row));
            r_col   <= IW'(16'(i_in_item.read_col));
            case (i_in_item.op)
                OP_CLEAR: begin
                    r_status <= ST_CLEARED;
                    r_rd_mem <= 1'b0;
                    r_wr_mem <= 1'b0;
                end
                OP_ADD: begin
                    r_status <= !in_win ? ST_OUTSIDE : (in_blind ? ST_BLIND : ST_STORED);
                    r_rd_mem <= 1'b0;
                    r_wr_mem <= in_win && !in_blind;
                end
                default: begin
                    r_status <= ST_READ;
                    r_rd_mem <= rd_ok;
                    r_wr_mem <= 1'b0;
                end
            endcase
        end
        if (r_state == S_DIV) begin
            r_q_x <= mul_x[DIV_SHIFT+15:DIV_SHIFT];
            r_q_y <= mul_y[DIV_SHIFT+15:DIV_SHIFT];
        end
        if (r_state == S_REM) begin
            r_qc_x <= qc_x;
            r_qc_y <= qc_y;
        end
        if (r_state == S_IDX) begin
            r_row <= q_x[IW-1:0];
            r_col <= q_y[IW-1:0];
            if (drop) begin
                r_status <= ST_OUTSIDE;
                r_wr_mem <= 1'b0;
            end
        end
        if (r_state == S_ADR) begin
            r_addr <= addr;
        end
    end

    // grid memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_mem_q <= mem[r_addr];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item.height_mm <= (r_rd_mem && mem_f) ? mem_h : 16'sd0;
            r_out_item.filled    <= r_rd_mem && mem_f;
            r_out_item.status    <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // a result is loaded only into a free or draining output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a waiting result");

    // no item is taken during a clearing pass
    a_no_accept_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweeping |-> !o_in_ready)
        else $error("input ready during clearing pass");

    // only a read result carries cell contents
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_READ)) |->
            (!o_out_item.filled && (o_out_item.height_mm == 16'sd0)))
        else $error("cell contents on a non-read result");

    // a cell index presented for addressing lies inside the grid
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADR) |-> ((16'(r_row) < GRID_16) && (16'(r_col) < GRID_16)))
        else $error("cell index out of grid");

    // a point write happens only together with its result
    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && !sweeping) |-> (out_load && (r_status == ST_STORED)))
        else $error("cell written without a stored result");

endmodule
